>>> hw/rtl/multi_policy_task_scheduler_macros.svh
// Assertion helpers used by the scheduler datapath.
`ifndef MULTI_POLICY_TASK_SCHEDULER_MACROS_SVH
`define MULTI_POLICY_TASK_SCHEDULER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define MPTS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MPTS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mpts_pkg.sv
package mpts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 2);
    localparam int TIME_W    = 24;
    localparam int QUANT_W   = 16;
    localparam int POL_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd500;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 2'd2;

    typedef enum logic [POL_W-1:0] {
        POL_FIFO = 2'd0,
        POL_RR   = 2'd1,
        POL_SJF  = 2'd2,
        POL_PSRT = 2'd3
    } t_policy;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CUR_RD,
        S_CUR_CHK,
        S_MOD,
        S_SCAN,
        S_PICK,
        S_CHG_RD,
        S_CHG_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic tick_start;
        logic cur_rd;
        logic cur_chk;
        logic mod_step;
        logic scan_step;
        logic pick;
        logic chg_rd;
        logic chg_wr;
        logic out_push;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic done_now;
        logic mod_done;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/mpts_ram.sv
module mpts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mpts_ctrl.sv
module mpts_ctrl
    import mpts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_kind == KIND_TICK) begin
                    n_state = i_sts.done ? S_OUT : S_CUR_RD;
                end
            end
            S_CUR_RD:  n_state = S_CUR_CHK;
            S_CUR_CHK: n_state = i_sts.done_now ? S_OUT : S_MOD;
            S_MOD: begin
                if (i_sts.mod_done) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_PICK;
            end
            S_PICK:   n_state = S_CHG_RD;
            S_CHG_RD: n_state = S_CHG_WR;
            S_CHG_WR: n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready         = 1'b1;
                o_cmd.load_wr      = i_in_valid && i_in_kind == KIND_LOAD;
                o_cmd.tick_start   = i_in_valid && i_in_kind == KIND_TICK;
            end
            S_CUR_RD:  o_cmd.cur_rd    = 1'b1;
            S_CUR_CHK: o_cmd.cur_chk   = 1'b1;
            S_MOD:     o_cmd.mod_step  = !i_sts.mod_done;
            S_SCAN:    o_cmd.scan_step = 1'b1;
            S_PICK:    o_cmd.pick      = 1'b1;
            S_CHG_RD:  o_cmd.chg_rd    = 1'b1;
            S_CHG_WR:  o_cmd.chg_wr    = 1'b1;
            S_OUT:     o_cmd.out_push  = i_sts.out_free;
            default:   o_cmd           = '0;
        endcase
    end

endmodule

>>> hw/rtl/mpts_datapath.sv
`include "multi_policy_task_scheduler_macros.svh"

module mpts_datapath
    import mpts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [IDX_W-1:0]     i_load_idx,
    input  logic [TIME_W-1:0]    i_load_ready,
    input  logic [TIME_W-1:0]    i_load_exec,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [15:0]          o_m_tdata
);

    t_policy              r_policy;
    logic [4:0]           r_task_count;
    logic [QUANT_W-1:0]   r_quantum;

    logic [MAX_TASKS-1:0] r_started;
    logic                 r_cur_valid;
    logic [IDX_W-1:0]     r_cur_slot;
    logic                 r_prev_valid;
    logic [IDX_W-1:0]     r_prev_slot;
    logic [TIME_W-1:0]    r_time;
    logic [QUANT_W-1:0]   r_slice;
    logic [CNT_W-1:0]     r_fin_cnt;
    logic                 r_done;
    logic                 r_fin_valid;
    logic [IDX_W-1:0]     r_fin_idx;

    logic [CNT_W-1:0]     r_mod;
    logic [CNT_W-1:0]     r_scan_cnt;
    logic                 r_has_rem;
    logic [IDX_W-1:0]     r_best_rem_idx;
    logic [TIME_W-1:0]    r_best_rem;
    logic                 r_has_rdy;
    logic [IDX_W-1:0]     r_best_rdy_idx;
    logic [TIME_W-1:0]    r_best_rdy;
    logic                 r_has_first;
    logic [IDX_W-1:0]     r_first_idx;
    logic                 r_has_hi;
    logic [IDX_W-1:0]     r_hi_idx;

    logic                 r_out_valid;
    logic [15:0]          r_out_data;

    logic [CNT_W-1:0]     w_n;
    logic [QUANT_W-1:0]   w_q;
    logic [IDX_W-1:0]     w_raddr;
    logic [TIME_W-1:0]    w_rd_ready;
    logic [TIME_W-1:0]    w_rd_rem;
    logic                 w_rem_we;
    logic [IDX_W-1:0]     w_rem_waddr;
    logic [TIME_W-1:0]    w_rem_wdata;
    logic [TIME_W-1:0]    w_exec_fix;
    logic                 w_retire;
    logic [CNT_W-1:0]     w_fin_cnt_nx;
    logic [IDX_W-1:0]     w_eval_idx;
    logic                 w_eval;
    logic                 w_started_nx;
    logic                 w_elig;
    logic                 w_found;
    logic [IDX_W-1:0]     w_pick_idx;
    logic                 w_switch;
    logic [QUANT_W:0]     w_slice_inc;

    assign w_n = (r_task_count > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : r_task_count;
    assign w_q = (r_quantum == '0) ? QUANT_W'(1) : r_quantum;
    assign w_exec_fix = (i_load_exec == '0) ? TIME_W'(1) : i_load_exec;

    assign w_raddr = (i_cmd.cur_rd || i_cmd.chg_rd) ? r_cur_slot : r_scan_cnt[IDX_W-1:0];

    assign w_rem_we    = i_cmd.load_wr ||
                         (i_cmd.chg_wr && r_cur_valid && w_rd_rem != '0);
    assign w_rem_waddr = i_cmd.load_wr ? i_load_idx : r_cur_slot;
    assign w_rem_wdata = i_cmd.load_wr ? w_exec_fix : w_rd_rem - TIME_W'(1);

    mpts_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr),
        .i_waddr (i_load_idx),
        .i_wdata (i_load_ready),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_ready)
    );

    mpts_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (w_rem_we),
        .i_waddr (w_rem_waddr),
        .i_wdata (w_rem_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_rem)
    );

    assign w_retire     = r_cur_valid && w_rd_rem == '0;
    assign w_fin_cnt_nx = r_fin_cnt + CNT_W'(w_retire);

    // scan data lags the address: the RAM read is registered
    assign w_eval       = i_cmd.scan_step && r_scan_cnt != '0;
    assign w_eval_idx   = IDX_W'(r_scan_cnt - CNT_W'(1));
    assign w_started_nx = r_started[w_eval_idx] || w_rd_ready == r_time;
    assign w_elig       = w_started_nx && w_rd_rem != '0;

    always_comb begin
        w_found    = 1'b0;
        w_pick_idx = r_cur_slot;
        if (r_cur_valid && (r_policy == POL_FIFO || r_policy == POL_SJF)) begin
            w_found = 1'b1;
        end else begin
            case (r_policy)
                POL_SJF, POL_PSRT: begin
                    w_found    = r_has_rem;
                    w_pick_idx = r_best_rem_idx;
                end
                POL_FIFO: begin
                    w_found    = r_has_rdy;
                    w_pick_idx = r_best_rdy_idx;
                end
                default: begin
                    if (!r_cur_valid && !r_prev_valid) begin
                        w_found    = r_has_first;
                        w_pick_idx = r_first_idx;
                    end else if (r_slice == '0 || !r_cur_valid) begin
                        // round robin continues after the previous slot, wrapping
                        w_found    = r_has_first;
                        w_pick_idx = r_has_hi ? r_hi_idx : r_first_idx;
                    end else begin
                        w_found = 1'b1;
                    end
                end
            endcase
        end
    end

    assign w_switch    = w_found && (!r_cur_valid || r_cur_slot != w_pick_idx);
    assign w_slice_inc = {1'b0, (w_switch ? QUANT_W'(0) : r_slice)} + (QUANT_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POL_FIFO;
            r_task_count <= 5'd1;
            r_quantum    <= QUANTUM_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_POLICY:     r_policy     <= t_policy'(i_cfg_data[POL_W-1:0]);
                CFG_TASK_COUNT: r_task_count <= i_cfg_data[4:0];
                CFG_QUANTUM:    r_quantum    <= i_cfg_data;
                default:        r_policy     <= r_policy;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= '0;
            r_cur_valid  <= 1'b0;
            r_cur_slot   <= '0;
            r_prev_valid <= 1'b0;
            r_prev_slot  <= '0;
            r_time       <= '0;
            r_slice      <= '0;
            r_fin_cnt    <= '0;
            r_done       <= 1'b0;
            r_fin_valid  <= 1'b0;
            r_fin_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_wr) begin
                r_started[i_load_idx] <= 1'b0;
            end
            if (i_cmd.tick_start) begin
                r_fin_valid <= 1'b0;
                r_fin_idx   <= '0;
            end
            if (i_cmd.cur_chk) begin
                if (w_retire) begin
                    r_fin_valid  <= 1'b1;
                    r_fin_idx    <= r_cur_slot;
                    r_prev_valid <= 1'b1;
                    r_prev_slot  <= r_cur_slot;
                    r_cur_valid  <= 1'b0;
                    r_fin_cnt    <= w_fin_cnt_nx;
                end
                if (w_fin_cnt_nx >= w_n) begin
                    r_done <= 1'b1;
                end
            end
            if (w_eval) begin
                r_started[w_eval_idx] <= w_started_nx;
            end
            if (i_cmd.pick) begin
                if (w_switch) begin
                    r_cur_valid  <= 1'b1;
                    r_cur_slot   <= w_pick_idx;
                    r_prev_valid <= 1'b1;
                    r_prev_slot  <= w_pick_idx;
                end
                r_slice <= (w_slice_inc >= {1'b0, w_q}) ? '0 : w_slice_inc[QUANT_W-1:0];
                r_time  <= r_time + TIME_W'(1);
            end
            if (i_cmd.out_push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan bookkeeping and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_chk) begin
            r_mod       <= {1'b0, (w_retire ? r_cur_slot : r_prev_slot)} + CNT_W'(1);
            r_scan_cnt  <= '0;
            r_has_rem   <= 1'b0;
            r_has_rdy   <= 1'b0;
            r_has_first <= 1'b0;
            r_has_hi    <= 1'b0;
        end
        if (i_cmd.mod_step) begin
            r_mod <= r_mod - w_n;
        end
        if (i_cmd.scan_step) begin
            r_scan_cnt <= r_scan_cnt + CNT_W'(1);
        end
        if (w_eval && w_elig) begin
            if (!r_has_rem || w_rd_rem < r_best_rem) begin
                r_has_rem      <= 1'b1;
                r_best_rem     <= w_rd_rem;
                r_best_rem_idx <= w_eval_idx;
            end
            if (!r_has_rdy || w_rd_ready < r_best_rdy) begin
                r_has_rdy      <= 1'b1;
                r_best_rdy     <= w_rd_ready;
                r_best_rdy_idx <= w_eval_idx;
            end
            if (!r_has_first) begin
                r_has_first <= 1'b1;
                r_first_idx <= w_eval_idx;
            end
            if (!r_has_hi && {1'b0, w_eval_idx} >= r_mod) begin
                r_has_hi <= 1'b1;
                r_hi_idx <= w_eval_idx;
            end
        end
        if (i_cmd.out_push) begin
            r_out_data <= {5'd0,
                           r_done,
                           r_fin_idx,
                           r_fin_valid,
                           (!r_done && r_cur_valid) ? r_cur_slot : IDX_W'(0),
                           !r_done && r_cur_valid};
        end
    end

    assign o_sts.done      = r_done;
    assign o_sts.done_now  = w_fin_cnt_nx >= w_n;
    assign o_sts.mod_done  = r_mod < w_n;
    assign o_sts.scan_done = r_scan_cnt == w_n;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `MPTS_ASSERT_ALWAYS(a_fin_cnt_bound, r_fin_cnt <= CNT_W'(MAX_TASKS), "finished count overflow")
    `MPTS_ASSERT_IMPL(a_no_pick_after_done, r_done, !i_cmd.pick, "pick after done")
    `MPTS_ASSERT_IMPL(a_push_when_free, i_cmd.out_push, !r_out_valid || i_m_tready,
        "output overwritten")

endmodule

>>> hw/rtl/multi_policy_task_scheduler.sv
// Load transfer: accepted while idle, no result.
// Tick transfer: current-slot read and check, round-robin start-slot modulo, serial scan of
// the N = tasks-in-use slots over the task RAMs, pick, remaining-time update, then result.
// One item in flight at a time; a tick after all tasks finish goes straight to its result.
// Reset (i_rst_n low, synchronous) clears scheduler state and loads register defaults;
// task tables hold garbage until loaded.
module multi_policy_task_scheduler
    import mpts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // task_index, ready_time, exec_time
    input  logic                 s_axis_tuser,  // kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // run_valid, run_index, finish_valid, finish_index, all_done
    output logic [15:0]          m_axis_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    mpts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mpts_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_load_idx   (s_axis_tdata[IDX_W-1:0]),
        .i_load_ready (s_axis_tdata[IDX_W +: TIME_W]),
        .i_load_exec  (s_axis_tdata[IDX_W+TIME_W +: TIME_W]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_m_tdata    (m_axis_tdata)
    );

endmodule

>>> bench/multi_policy_task_scheduler_tb.sv
`timescale 1ns / 1ps

module multi_policy_task_scheduler_tb;
    import mpts_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;

    // Task table model plus the queue of tick outcomes still owed by the block.
    class sched_board;
        logic [TIME_W-1:0]  ready_at  [MAX_TASKS];
        logic [TIME_W-1:0]  work_left [MAX_TASKS];
        bit                 started   [MAX_TASKS];
        bit                 cur_v;
        logic [IDX_W-1:0]   cur_s;
        bit                 prev_v;
        logic [IDX_W-1:0]   prev_s;
        logic [TIME_W-1:0]  now;
        int                 slice;
        int                 fin_cnt;
        bit                 done;
        t_policy            pol;
        logic [4:0]         tcount;
        logic [QUANT_W-1:0] quant;
        logic [15:0]        tick_outcomes [$];
        int                 errors;

        function new();
            for (int i = 0; i < MAX_TASKS; i++) begin
                ready_at[i] = '0;
                work_left[i] = '0;
                started[i] = 0;
            end
            cur_v = 0; cur_s = '0; prev_v = 0; prev_s = '0;
            now = '0; slice = 0; fin_cnt = 0; done = 0;
            pol = POL_FIFO; tcount = 5'd1; quant = QUANTUM_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == CFG_POLICY) pol = t_policy'(data[POL_W-1:0]);
            else if (idx == CFG_TASK_COUNT) tcount = data[4:0];
            else if (idx == CFG_QUANTUM) quant = data[QUANT_W-1:0];
        endfunction

        function int in_use();
            return (tcount > MAX_TASKS) ? MAX_TASKS : int'(tcount);
        endfunction

        function bit can_run(int i);
            return started[i] && work_left[i] != 0;
        endfunction

        function int pick_slot(int n);
            int best;
            int s;
            best = -1;
            if (cur_v && (pol == POL_FIFO || pol == POL_SJF)) return int'(cur_s);
            if (pol == POL_SJF || pol == POL_PSRT) begin
                for (int i = 0; i < n; i++)
                    if (can_run(i) && (best < 0 || work_left[i] < work_left[best])) best = i;
            end else if (pol == POL_FIFO) begin
                for (int i = 0; i < n; i++)
                    if (can_run(i) && (best < 0 || ready_at[i] < ready_at[best])) best = i;
            end else if (!cur_v && !prev_v) begin
                for (int i = 0; i < n; i++)
                    if (best < 0 && can_run(i)) best = i;
            end else if (slice == 0 || !cur_v) begin
                // round robin: next runnable slot after the last one switched to
                for (int k = 1; k <= n; k++) begin
                    s = (int'(prev_s) + k) % n;
                    if (best < 0 && can_run(s)) best = s;
                end
            end else begin
                best = int'(cur_s);
            end
            return best;
        endfunction

        function void note_input(logic kind, logic [IDX_W-1:0] idx,
                                 logic [TIME_W-1:0] rt, logic [TIME_W-1:0] et);
            int n;
            int nx;
            int q;
            bit fv;
            logic [IDX_W-1:0] fi;
            bit rv;
            logic [IDX_W-1:0] ri;
            if (kind == KIND_LOAD) begin
                ready_at[idx] = rt;
                work_left[idx] = (et == 0) ? TIME_W'(1) : et;
                started[idx] = 0;
                return;
            end
            if (done) begin
                tick_outcomes.push_back(16'h0400);
                return;
            end
            n = in_use();
            fv = 0; fi = '0; rv = 0; ri = '0;
            if (cur_v && work_left[cur_s] == 0) begin
                fv = 1; fi = cur_s;
                prev_v = 1; prev_s = cur_s;
                cur_v = 0;
                fin_cnt++;
            end
            if (fin_cnt >= n) begin
                done = 1;
                tick_outcomes.push_back({5'd0, 1'b1, fi, fv, 4'd0, 1'b0});
                return;
            end
            for (int i = 0; i < n; i++)
                if (ready_at[i] == now) started[i] = 1;
            nx = pick_slot(n);
            if (nx >= 0 && (!cur_v || int'(cur_s) != nx)) begin
                cur_v = 1; cur_s = nx[IDX_W-1:0];
                prev_v = 1; prev_s = nx[IDX_W-1:0];
                slice = 0;
            end
            if (cur_v) begin
                if (work_left[cur_s] != 0) work_left[cur_s]--;
                rv = 1; ri = cur_s;
            end
            q = (quant == 0) ? 1 : int'(quant);
            slice++;
            if (slice >= q) slice = 0;
            now++;
            tick_outcomes.push_back({5'd0, 1'b0, fi, fv, ri, rv});
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [15:0] got);
            logic [15:0] want;
            if (tick_outcomes.size() == 0) begin
                report("unexpected transfer", got, 0);
                return;
            end
            want = tick_outcomes.pop_front();
            if (got[0] !== want[0]) report("run_valid", got[0], want[0]);
            if (got[4:1] !== want[4:1]) report("run_index", got[4:1], want[4:1]);
            if (got[5] !== want[5]) report("finish_valid", got[5], want[5]);
            if (got[9:6] !== want[9:6]) report("finish_index", got[9:6], want[9:6]);
            if (got[10] !== want[10]) report("all_done", got[10], want[10]);
            if (got[15:11] !== want[15:11]) report("pad bits", got[15:11], 0);
        endtask
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 s_axis_tvalid = 0;
    logic                 s_axis_tready;
    logic [55:0]          s_axis_tdata = '0;  // task_index, ready_time, exec_time
    logic                 s_axis_tuser = 0;   // kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 0;
    logic [15:0]          m_axis_tdata;       // run_valid, run_index, finish_valid,
                                              // finish_index, all_done

    sched_board sb = new();
    bit quiet = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int cycles = 0;

    multi_policy_task_scheduler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls plus the requested long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left == 0 && stall_left == 0 && !quiet && $urandom_range(0, 12) == 0)
                stall_left = $urandom_range(1, 9);
            m_axis_tready <= (hold_left == 0 && stall_left == 0);
            if (hold_left > 0) hold_left--;
            else if (stall_left > 0) stall_left--;
        end
    end

    task send_item(logic kind, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] rt,
                   logic [TIME_W-1:0] et);
        s_axis_tvalid <= 1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {4'd0, et, rt, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(kind, idx, rt, et);
    endtask

    task maybe_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.tick_outcomes.size() != 0) @(posedge i_clk);
        // loads leave no result; give the block time to settle
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_wr_en <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task tick();
        send_item(KIND_TICK, IDX_W'($urandom_range(0, 15)), TIME_W'($urandom),
                  TIME_W'($urandom));
    endtask

    task rand_item();
        logic [TIME_W-1:0] rt;
        logic [TIME_W-1:0] et;
        if ($urandom_range(0, 9) < 3) begin
            rt = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                             : sb.now + TIME_W'($urandom_range(0, 15));
            case ($urandom_range(0, 19))
                0, 1:    et = TIME_W'($urandom_range(0, 3));
                2:       et = TIME_W'($urandom);
                default: et = TIME_W'($urandom_range(60, 300));
            endcase
            send_item(KIND_LOAD, IDX_W'($urandom_range(0, 15)), rt, et);
        end else begin
            tick();
        end
        maybe_gap();
    endtask

    initial begin
        t_policy pols [6];
        logic [15:0] quants [6];
        pols = '{POL_FIFO, POL_RR, POL_SJF, POL_PSRT, POL_RR, POL_PSRT};
        quants = '{16'd3, 16'd1, 16'd65535, 16'd0, 16'd7, 16'd2};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(posedge i_clk);
        cfg_write(CFG_TASK_COUNT, 16'd16);
        cfg_write(CFG_POLICY, CFG_DAT_W'(POL_FIFO));
        cfg_write(CFG_QUANTUM, 16'd3);

        // directed: every slot loaded, extremes of times, zero work
        for (int i = 0; i < MAX_TASKS; i++)
            send_item(KIND_LOAD, IDX_W'(i), TIME_W'(i), TIME_W'((i % 4 == 0) ? 0 : 40 + i));
        send_item(KIND_LOAD, 4'd15, 24'hFFFFFF, 24'hFFFFFF);
        send_item(KIND_LOAD, 4'd14, 24'h000000, 24'hFFFFFF);
        send_item(KIND_LOAD, 4'd14, 24'd3, 24'd1);
        repeat (6) tick();

        for (int p = 0; p < 6; p++) begin
            drain();
            cfg_write(CFG_POLICY, CFG_DAT_W'(pols[p]));
            cfg_write(CFG_QUANTUM, (p == 5) ? 16'($urandom_range(1, 20)) : quants[p]);
            for (int k = 0; k < 280; k++) begin
                if (p == 1 && k == 100) hold_asked++;
                if (p == 2 && k == 100) begin
                    s_axis_tvalid <= 0;
                    @(posedge i_clk);
                    while (sb.tick_outcomes.size() != 0) @(posedge i_clk);
                end
                rand_item();
            end
        end

        // closing part without idling: small and out-of-range task counts
        quiet = 1;
        drain();
        cfg_write(CFG_TASK_COUNT, 16'd1);
        cfg_write(CFG_QUANTUM, 16'hFFFF);
        repeat (20) rand_item();
        drain();
        cfg_write(CFG_TASK_COUNT, 16'd0);
        repeat (10) tick();
        drain();
        cfg_write(CFG_TASK_COUNT, 16'd31);
        cfg_write(CFG_POLICY, CFG_DAT_W'(POL_SJF));
        repeat (10) tick();
        s_axis_tvalid <= 0;
        while (sb.tick_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
